@@ hdl/gla_pkg.sv @@
// Shared types, codes and defaults for the grouped leaf allocator.
package gla_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int MAX_GROUPS_DEF = 16;

  localparam int GRP_W    = 8;
  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 13;
  localparam int ENTRY_W  = GRP_W + SLOT_W;
  localparam int ADDR_CALC_W = 17;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_INVALID   = 2'd2,
    ST_NOT_USED  = 2'd3
  } gla_status_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } gla_action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_ALLOC,
    S_FREE
  } gla_state_t;

  typedef struct packed {
    logic load;
    logic fill;
    logic pop;
    logic alloc_fin;
    logic bm_read;
    logic free_fin;
    logic exhaust;
    logic invalid;
  } gla_cmd_t;

  typedef struct packed {
    gla_action_t action;
    logic        top_zero;
    logic        groups_full;
    logic        free_bad;
    logic        fill_last;
    logic        out_free;
  } gla_stat_t;

endpackage

@@ hdl/gla_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gla_ram import gla_pkg::*; #(
  parameter int WIDTH = ENTRY_W,
  parameter int DEPTH = SLOTS_DEF * MAX_GROUPS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/gla_ctrl.sv @@
// Controller state machine that sequences allocate, free and group opening.
module gla_ctrl import gla_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  gla_stat_t stat,
  output gla_cmd_t  cmd
);

  gla_state_t state_r, state_nxt;
  logic       commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    commit = 1'b0;
    case (state_r)
      S_EXEC: begin
        if (stat.action == ACT_ALLOC) begin
          commit = stat.top_zero && stat.groups_full && stat.out_free;
        end else begin
          commit = stat.free_bad && stat.out_free;
        end
      end
      S_ALLOC, S_FREE: commit = stat.out_free;
      default:         commit = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt = in_tvalid ? S_EXEC : S_IDLE;
        end else if (stat.action == ACT_ALLOC) begin
          if (!stat.top_zero) begin
            state_nxt = S_ALLOC;
          end else if (!stat.groups_full) begin
            state_nxt = S_FILL;
          end
        end else if (!stat.free_bad) begin
          state_nxt = S_FREE;
        end
      end
      S_FILL: begin
        if (stat.fill_last) state_nxt = S_EXEC;
      end
      S_ALLOC, S_FREE: begin
        if (commit) state_nxt = in_tvalid ? S_EXEC : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_EXEC: begin
        if (stat.action == ACT_ALLOC) begin
          if (!stat.top_zero) begin
            cmd.pop = 1'b1;
          end else if (stat.groups_full) begin
            cmd.exhaust = stat.out_free;
          end
        end else if (stat.free_bad) begin
          cmd.invalid = stat.out_free;
        end else begin
          cmd.bm_read = 1'b1;
        end
      end
      S_FILL:  cmd.fill      = 1'b1;
      S_ALLOC: cmd.alloc_fin = stat.out_free;
      S_FREE:  cmd.free_fin  = stat.out_free;
      default: cmd = '0;
    endcase
    if (commit) in_tready = 1'b1;
    cmd.load = in_tready && in_tvalid;
  end

endmodule

@@ hdl/gla_dp.sv @@
// Datapath: free stack, used bitmap, counters, start pointer and result register.
module gla_dp import gla_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gla_cmd_t              cmd,
  output gla_stat_t             stat,
  input  logic                  in_action,
  input  logic [GRP_W-1:0]      in_group,
  input  logic [SLOT_W-1:0]     in_slot,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int DEPTH = SLOTS * MAX_GROUPS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int NGW   = $clog2(MAX_GROUPS + 2);
  localparam int CW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  gla_action_t       act_r;
  logic [GRP_W-1:0]  tg_r;
  logic [SLOT_W-1:0] ts_r;

  logic [TW-1:0]     top_r, top_nxt;
  logic [NGW-1:0]    ng_r;
  logic [CW-1:0]     cnt_r;
  logic [GRP_W-1:0]  start_g_r, start_g_nxt;
  logic [SLOT_W-1:0] start_s_r, start_s_nxt;

  logic              out_valid_r;
  gla_status_t       res_status_r;
  logic [GRP_W-1:0]  res_group_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic [GRP_W-1:0]  res_sg_r;
  logic [SLOT_W-1:0] res_ss_r;
  logic [COUNT_W-1:0] res_count_r;

  logic              st_we;
  logic [AW-1:0]     st_waddr;
  logic [ENTRY_W-1:0] st_wdata;
  logic [AW-1:0]     st_raddr;
  logic [ENTRY_W-1:0] st_rdata;
  logic [GRP_W-1:0]  pop_g;
  logic [SLOT_W-1:0] pop_s;

  logic              bm_we;
  logic [AW-1:0]     bm_waddr;
  logic [0:0]        bm_wdata;
  logic [AW-1:0]     bm_raddr;
  logic [0:0]        bm_rdata;

  logic              push_ok;
  logic              pop_in_range;
  logic              res_load;
  gla_status_t       res_status;
  logic [GRP_W-1:0]  res_group;
  logic [SLOT_W-1:0] res_slot;

  function automatic logic [AW-1:0] bm_addr(input logic [GRP_W-1:0] g,
                                            input logic [SLOT_W-1:0] s);
    logic [ADDR_CALC_W-1:0] a;
    a = (ADDR_CALC_W'(g) - ADDR_CALC_W'(1)) * ADDR_CALC_W'(SLOTS) + ADDR_CALC_W'(s);
    return a[AW-1:0];
  endfunction

  assign pop_g        = st_rdata[ENTRY_W-1:SLOT_W];
  assign pop_s        = st_rdata[SLOT_W-1:0];
  assign push_ok      = top_r < TW'(DEPTH);
  assign pop_in_range = (pop_g != '0) && ({1'b0, pop_g} <= (GRP_W+1)'(MAX_GROUPS)) &&
                        ({1'b0, pop_s} < (SLOT_W+1)'(SLOTS));

  assign stat.action      = act_r;
  assign stat.top_zero    = top_r == '0;
  assign stat.groups_full = ng_r > NGW'(MAX_GROUPS);
  assign stat.free_bad    = (tg_r == '0) || ((NGW+GRP_W)'(tg_r) >= (NGW+GRP_W)'(ng_r)) ||
                            ({1'b0, ts_r} >= (SLOT_W+1)'(SLOTS));
  assign stat.fill_last   = cnt_r == CW'(SLOTS - 1);
  assign stat.out_free    = !out_valid_r || out_ready;

  always_comb begin
    st_we    = 1'b0;
    st_waddr = top_r[AW-1:0];
    st_wdata = {GRP_W'(ng_r), SLOT_W'(cnt_r)};
    bm_we    = 1'b0;
    bm_waddr = bm_addr(GRP_W'(ng_r), SLOT_W'(cnt_r));
    bm_wdata = 1'b0;
    top_nxt  = top_r;
    if (cmd.fill) begin
      st_we   = 1'b1;
      bm_we   = 1'b1;
      top_nxt = top_r + TW'(1);
    end else if (cmd.pop) begin
      top_nxt = top_r - TW'(1);
    end else if (cmd.alloc_fin) begin
      bm_we    = pop_in_range;
      bm_waddr = bm_addr(pop_g, pop_s);
      bm_wdata = 1'b1;
    end else if (cmd.free_fin && bm_rdata[0]) begin
      bm_we    = 1'b1;
      bm_waddr = bm_addr(tg_r, ts_r);
      st_we    = push_ok;
      st_wdata = {tg_r, ts_r};
      if (push_ok) top_nxt = top_r + TW'(1);
    end
  end

  assign st_raddr = AW'(top_r - TW'(1));
  assign bm_raddr = bm_addr(tg_r, ts_r);

  always_comb begin
    start_g_nxt = start_g_r;
    start_s_nxt = start_s_r;
    if (cmd.alloc_fin && start_g_r == '0) begin
      start_g_nxt = pop_g;
      start_s_nxt = pop_s;
    end
  end

  always_comb begin
    res_load   = cmd.alloc_fin || cmd.free_fin || cmd.exhaust || cmd.invalid;
    res_status = ST_OK;
    res_group  = '0;
    res_slot   = '0;
    if (cmd.alloc_fin) begin
      res_group = pop_g;
      res_slot  = pop_s;
    end else if (cmd.exhaust) begin
      res_status = ST_EXHAUSTED;
    end else if (cmd.invalid) begin
      res_status = ST_INVALID;
    end else if (cmd.free_fin && !bm_rdata[0]) begin
      res_status = ST_NOT_USED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      ng_r        <= NGW'(1);
      cnt_r       <= '0;
      start_g_r   <= '0;
      start_s_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      top_r     <= top_nxt;
      start_g_r <= start_g_nxt;
      start_s_r <= start_s_nxt;
      if (cmd.fill) begin
        cnt_r <= stat.fill_last ? '0 : cnt_r + CW'(1);
        if (stat.fill_last) ng_r <= ng_r + NGW'(1);
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= gla_action_t'(in_action);
      tg_r  <= in_group;
      ts_r  <= in_slot;
    end
    if (res_load) begin
      res_status_r <= res_status;
      res_group_r  <= res_group;
      res_slot_r   <= res_slot;
      res_sg_r     <= start_g_nxt;
      res_ss_r     <= start_s_nxt;
      res_count_r  <= COUNT_W'(top_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = {1'b0, res_count_r, res_ss_r, res_sg_r, res_slot_r, res_group_r,
                      res_status_r};

  gla_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (cmd.pop),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  gla_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .re    (cmd.bm_read),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= TW'(DEPTH))
    else $error("free stack count beyond depth");

  a_group_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ng_r <= NGW'(MAX_GROUPS + 1))
    else $error("next group beyond limit");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> top_r != '0)
    else $error("pop from empty free stack");

  a_start_set: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_fin |=> start_g_r != '0)
    else $error("start pointer not recorded after allocation");

endmodule

@@ hdl/grouped_leaf_allocator_core.sv @@
// Top level of the grouped slot allocator with free stack and used bitmap.
// Usage: each input item is an allocate (in_tuser = 0) or a free (in_tuser = 1)
// request; every accepted item yields exactly one result item on the out_ channel.
// A result carries status, allocated group and slot, the first allocation ever
// made and the free stack count after the request.
// Sequence: an allocate or free reads the stack or bitmap in the execute state
// and loads the result register in the allocate or free state, where the next
// item is accepted. A free rejected as an invalid pointer and an allocate that
// finds every group open load their result from the execute state. An allocate
// that finds the free stack empty first opens the next group, pushing its SLOTS
// entries at one per cycle, then pops as above; both memories have registered reads.
// Reset: rst_n low clears the stack count, the start pointer and the result
// valid flag and sets the next group to one; memory contents stay undefined,
// since a group's bitmap row is cleared as the group opens.
// Stall: a result waits in the output register while out_tready is low; the
// next item is still accepted and processed up to its own result, then holds.
module grouped_leaf_allocator_core import gla_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // target_group[7:0], target_slot[15:8]
  input  logic                  in_tuser,   // action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // status[1:0], out_group[9:2],
                                            // out_slot[17:10], start_group[25:18],
                                            // start_slot[33:26], free_count[46:34]
);

  gla_cmd_t  cmd;
  gla_stat_t stat;

  gla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gla_dp #(.SLOTS(SLOTS), .MAX_GROUPS(MAX_GROUPS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_action (in_tuser),
    .in_group  (in_tdata[GRP_W-1:0]),
    .in_slot   (in_tdata[IN_DATA_W-1:GRP_W]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
